@@ src/kfrm_pkg.sv @@
// Package for the k-mer flank repeat matcher.
// Holds the sizing constants, operation and result codes, payload and control structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package kfrm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KMER_BITS   = 32;

    localparam int KMER_IN_W = 32;
    localparam int KEY_W     = (KMER_BITS < KMER_IN_W) ? KMER_BITS : KMER_IN_W;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int OP_W      = 3;
    localparam int LIMIT_W   = 8;
    localparam int HITS_W    = 8;
    localparam int KIND_W    = 2;
    localparam int GAP_W     = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

    localparam logic [OP_W-1:0] OP_CLEAR      = OP_W'(0);
    localparam logic [OP_W-1:0] OP_APPEND_FWD = OP_W'(1);
    localparam logic [OP_W-1:0] OP_APPEND_REV = OP_W'(2);
    localparam logic [OP_W-1:0] OP_LEFT       = OP_W'(3);
    localparam logic [OP_W-1:0] OP_RIGHT      = OP_W'(4);
    localparam logic [OP_W-1:0] OP_FINISH     = OP_W'(5);

    localparam logic [KIND_W-1:0] KIND_NONE = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_FWD  = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_REV  = KIND_W'(2);

    localparam logic [GAP_W-1:0] GAP_NONE   = GAP_W'(0);
    localparam logic [GAP_W-1:0] GAP_CENTER = GAP_W'(1);
    localparam logic [GAP_W-1:0] GAP_RIGHT  = GAP_W'(2);
    localparam logic [GAP_W-1:0] GAP_LEFT   = GAP_W'(3);

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [KMER_IN_W-1:0] kmer_value;
    } kfrm_in_t;

    typedef struct packed {
        logic              left_matched;
        logic              right_matched;
        logic [KIND_W-1:0] left_hit_kind;
        logic [KIND_W-1:0] right_hit_kind;
        logic [GAP_W-1:0]  gap_class;
        logic              any_match;
        logic              table_overflow;
    } kfrm_out_t;

    typedef struct packed {
        logic clear;
        logic append_fwd;
        logic append_rev;
        logic load_key;
        logic side_right;
        logic scan_step;
        logic update;
        logic report;
    } kfrm_cmd_t;

    typedef struct packed {
        logic left_done;
        logic right_done;
        logic scan_last;
    } kfrm_sts_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } kfrm_state_t;

endpackage

`default_nettype wire

@@ src/kfrm_ctrl.sv @@
// Controller state machine of the k-mer flank repeat matcher.
// Decodes each accepted transaction into datapath commands; depends on kfrm_pkg.
`default_nettype none

module kfrm_ctrl
    import kfrm_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [OP_W-1:0] operation,
    input  wire kfrm_sts_t       sts,
    output logic                 busy,
    output kfrm_cmd_t            cmd
);

    kfrm_state_t state_reg;
    kfrm_state_t state_next;
    logic        live_left;
    logic        live_right;

    assign live_left  = start && (operation == OP_LEFT) && !sts.left_done;
    assign live_right = start && (operation == OP_RIGHT) && !sts.right_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (live_left || live_right)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.clear      = start && (operation == OP_CLEAR);
                cmd.append_fwd = start && (operation == OP_APPEND_FWD);
                cmd.append_rev = start && (operation == OP_APPEND_REV);
                cmd.report     = start && (operation == OP_FINISH);
                cmd.load_key   = live_left || live_right;
                cmd.side_right = live_right;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/kfrm_dp.sv @@
// Datapath of the k-mer flank repeat matcher: both k-mer tables, fill counts,
// the scan pipeline, per-side hit state and the result register; depends on kfrm_pkg.
`default_nettype none

module kfrm_dp
    import kfrm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kfrm_cmd_t            cmd,
    input  wire logic [KMER_IN_W-1:0] kmer_value,
    input  wire logic                 cfg_we,
    input  wire logic [LIMIT_W-1:0]   cfg_data,
    output kfrm_sts_t                 sts,
    output kfrm_out_t                 result,
    output logic                      result_valid
);

    logic [KEY_W-1:0]   fwd_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]   rev_mem [TABLE_DEPTH];

    logic [KEY_W-1:0]   key_in;
    logic [KEY_W-1:0]   key_reg;
    logic               side_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   fwd_cnt_reg;
    logic [CNT_W-1:0]   rev_cnt_reg;
    logic [CNT_W-1:0]   scan_end;
    logic [KEY_W-1:0]   fwd_rdata_reg;
    logic [KEY_W-1:0]   rev_rdata_reg;
    logic               fwd_rdv_reg;
    logic               rev_rdv_reg;
    logic               fwd_found_reg;
    logic               rev_found_reg;
    logic               fwd_issue;
    logic               rev_issue;
    logic               fwd_full;
    logic               rev_full;
    logic [HITS_W-1:0]  left_hits_reg;
    logic [HITS_W-1:0]  right_hits_reg;
    logic               left_done_reg;
    logic               right_done_reg;
    logic [KIND_W-1:0]  left_kind_reg;
    logic [KIND_W-1:0]  right_kind_reg;
    logic               ovf_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               hit_any;
    logic [KIND_W-1:0]  kind_next;
    logic [HITS_W-1:0]  side_hits;
    logic [HITS_W:0]    total_next;
    logic [HITS_W-1:0]  hits_next;
    logic               done_next;
    kfrm_out_t          result_next;
    kfrm_out_t          result_reg;
    logic               result_valid_reg;

    assign key_in    = kmer_value[KEY_W-1:0];
    assign fwd_full  = fwd_cnt_reg >= CNT_W'(TABLE_DEPTH);
    assign rev_full  = rev_cnt_reg >= CNT_W'(TABLE_DEPTH);
    assign scan_end  = (fwd_cnt_reg > rev_cnt_reg) ? fwd_cnt_reg : rev_cnt_reg;
    assign fwd_issue = cmd.scan_step && (idx_reg < fwd_cnt_reg);
    assign rev_issue = cmd.scan_step && (idx_reg < rev_cnt_reg);

    assign sts.left_done  = left_done_reg;
    assign sts.right_done = right_done_reg;
    assign sts.scan_last  = (idx_reg == scan_end);

    always_ff @(posedge clk)
    begin
        if (cmd.append_fwd && !fwd_full)
        begin
            fwd_mem[fwd_cnt_reg[ADDR_W-1:0]] <= key_in;
        end
        if (fwd_issue)
        begin
            fwd_rdata_reg <= fwd_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append_rev && !rev_full)
        begin
            rev_mem[rev_cnt_reg[ADDR_W-1:0]] <= key_in;
        end
        if (rev_issue)
        begin
            rev_rdata_reg <= rev_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= key_in;
        end
    end

    assign hit_any    = fwd_found_reg || rev_found_reg;
    assign kind_next  = fwd_found_reg ? KIND_FWD : KIND_REV;
    assign side_hits  = side_reg ? right_hits_reg : left_hits_reg;
    assign total_next = {1'b0, side_hits} + {{HITS_W{1'b0}}, hit_any};
    assign hits_next  = total_next[HITS_W] ? {HITS_W{1'b1}} : total_next[HITS_W-1:0];
    assign done_next  = total_next > (HITS_W + 1)'(limit_reg);

    always_comb
    begin
        result_next                = '0;
        result_next.left_matched   = left_done_reg;
        result_next.right_matched  = right_done_reg;
        result_next.left_hit_kind  = left_kind_reg;
        result_next.right_hit_kind = right_kind_reg;
        result_next.any_match      = left_done_reg || right_done_reg;
        result_next.table_overflow = ovf_reg;
        if (left_done_reg && right_done_reg)
        begin
            result_next.gap_class = GAP_CENTER;
        end
        else if (left_done_reg)
        begin
            result_next.gap_class = GAP_RIGHT;
        end
        else if (right_done_reg)
        begin
            result_next.gap_class = GAP_LEFT;
        end
        else
        begin
            result_next.gap_class = GAP_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg         <= 1'b0;
            idx_reg          <= '0;
            fwd_cnt_reg      <= '0;
            rev_cnt_reg      <= '0;
            fwd_rdv_reg      <= 1'b0;
            rev_rdv_reg      <= 1'b0;
            fwd_found_reg    <= 1'b0;
            rev_found_reg    <= 1'b0;
            left_hits_reg    <= '0;
            right_hits_reg   <= '0;
            left_done_reg    <= 1'b0;
            right_done_reg   <= 1'b0;
            left_kind_reg    <= KIND_NONE;
            right_kind_reg   <= KIND_NONE;
            ovf_reg          <= 1'b0;
            limit_reg        <= LIMIT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_rdv_reg      <= fwd_issue;
            rev_rdv_reg      <= rev_issue;
            result_valid_reg <= cmd.report;

            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end

            if (cmd.clear)
            begin
                fwd_cnt_reg    <= '0;
                rev_cnt_reg    <= '0;
                left_hits_reg  <= '0;
                right_hits_reg <= '0;
                left_done_reg  <= 1'b0;
                right_done_reg <= 1'b0;
                left_kind_reg  <= KIND_NONE;
                right_kind_reg <= KIND_NONE;
                ovf_reg        <= 1'b0;
            end

            if (cmd.append_fwd)
            begin
                if (fwd_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    fwd_cnt_reg <= fwd_cnt_reg + CNT_W'(1);
                end
            end

            if (cmd.append_rev)
            begin
                if (rev_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    rev_cnt_reg <= rev_cnt_reg + CNT_W'(1);
                end
            end

            if (cmd.load_key)
            begin
                side_reg      <= cmd.side_right;
                idx_reg       <= '0;
                fwd_found_reg <= 1'b0;
                rev_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step && !sts.scan_last)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (fwd_rdv_reg && (fwd_rdata_reg == key_reg))
                begin
                    fwd_found_reg <= 1'b1;
                end
                if (rev_rdv_reg && (rev_rdata_reg == key_reg))
                begin
                    rev_found_reg <= 1'b1;
                end
            end

            if (cmd.update)
            begin
                if (side_reg)
                begin
                    right_hits_reg <= hits_next;
                    right_done_reg <= done_next;
                    if (hit_any)
                    begin
                        right_kind_reg <= kind_next;
                    end
                end
                else
                begin
                    left_hits_reg <= hits_next;
                    left_done_reg <= done_next;
                    if (hit_any)
                    begin
                        left_kind_reg <= kind_next;
                    end
                end
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

`ifndef NO_ASSERTIONS
    a_fwd_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("Forward table fill count exceeds the table depth.");

    a_left_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        left_done_reg && !cmd.clear |=> left_done_reg)
        else $error("Left side lost its matched state without a clear.");

    a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clear |=> (left_hits_reg >= $past(left_hits_reg)))
        else $error("Left hit counter decreased without a clear.");

    a_rdata_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_rdv_reg || rev_rdv_reg |-> $past(cmd.scan_step))
        else $error("Table read data marked valid outside a scan.");

    a_scan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !cmd.report && !cmd.clear && !cmd.append_fwd && !cmd.append_rev)
        else $error("Table or result command issued during a scan.");
`endif

endmodule

`default_nettype wire

@@ src/kmer_flank_repeat_matcher.sv @@
// Top level of the k-mer flank repeat matcher.
// Joins the controller and the datapath; depends on kfrm_pkg, kfrm_ctrl and kfrm_dp.
//
// A transaction is taken at a rising edge with start high and busy low; the
// command struct carries the operation and the k-mer. Clear, append and finish
// leave busy low. A finish puts its result on the result struct with
// result_valid high for exactly one cycle, the cycle after it was taken; the
// receiver cannot hold it off. A flank transaction on a side that is not yet
// matched scans both tables in parallel, one entry of each per cycle, and
// holds busy high through the scan of the fuller table and the update of that
// side's hit state. A flank transaction on a matched side leaves busy low.
// The limit register is written through cfg_valid/cfg_ready/cfg_data; ready
// follows busy low. Reset empties both tables, clears all hit state and the
// overflow flag, and loads a limit of 3; no clearing pass is needed.
`default_nettype none

module kmer_flank_repeat_matcher
    import kfrm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire kfrm_in_t           command,
    output kfrm_out_t               result,
    output logic                    result_valid,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LIMIT_W-1:0] cfg_data
);

    kfrm_cmd_t cmd;
    kfrm_sts_t sts;

    assign cfg_ready = !busy;

    kfrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (command.operation),
        .sts       (sts),
        .busy      (busy),
        .cmd       (cmd)
    );

    kfrm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kmer_value   (command.kmer_value),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire
